FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file ic2d_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/ic2d_pkg.sv
// ----------------------------------------------------------------------------
// ic2d_pkg
// Shared types, codes and defaults of the 2D convolution core.
// ----------------------------------------------------------------------------
package ic2d_pkg;

  localparam int MAX_WIDTH_DEF      = 2048;
  localparam int MAX_KERNEL_DEF     = 7;
  localparam int COEF_FRAC_BITS_DEF = 10;

  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_DRAIN = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [2:0] CFG_IMG_W = 3'd0;
  localparam logic [2:0] CFG_IMG_H = 3'd1;
  localparam logic [2:0] CFG_KER_W = 3'd2;
  localparam logic [2:0] CFG_KER_H = 3'd3;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_DONE
  } back_state_e;

  // line buffer address width: power-of-two ring with slack for queued words
  function automatic int line_aw(input int mw, input int mk);
    return $clog2((mk - 1) * mw + mk + 16);
  endfunction

endpackage

FILE: sv/ic2d_ram.sv
// ----------------------------------------------------------------------------
// ic2d_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ic2d_ram #(
  parameter int W  = 16,
  parameter int D  = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ic2d_queue.sv
// ----------------------------------------------------------------------------
// ic2d_queue
// Two-entry job queue between front end and MAC back end.
// ----------------------------------------------------------------------------
module ic2d_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  logic [DW-1:0] ent_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  assign data_o  = ent_q[rd_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

endmodule

FILE: sv/ic2d_front.sv
// ----------------------------------------------------------------------------
// ic2d_front
// Front end: takes words, fills coefficient and line stores, tracks frame
// position and queues one job per output pixel.
// ----------------------------------------------------------------------------
module ic2d_front #(
  parameter int MAX_WIDTH  = ic2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ic2d_pkg::MAX_KERNEL_DEF,
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int KW_W  = $clog2(MAX_KERNEL + 1),
  localparam int LAW   = ic2d_pkg::line_aw(MAX_WIDTH, MAX_KERNEL),
  localparam int CD    = MAX_KERNEL * MAX_KERNEL,
  localparam int CAW   = (CD > 1) ? $clog2(CD) : 1,
  localparam int QW    = 16 + WW + LAW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_clear_i,
  input  logic [WW-1:0]     w_i,
  input  logic [15:0]       h_i,
  input  logic [KW_W-1:0]   kw_i,
  input  logic [KW_W-1:0]   kh_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [5:0]        coef_index_i,
  input  logic signed [17:0] coef_value_i,
  input  logic [15:0]       pixel_sample_i,
  input  logic              back_idle_i,
  input  logic              q_full_i,
  input  logic              q_empty_i,
  output logic              q_push_o,
  output logic [QW-1:0]     q_data_o,
  output logic              line_we_o,
  output logic [LAW-1:0]    line_waddr_o,
  output logic [15:0]       line_wdata_o,
  output logic              coef_we_o,
  output logic [CAW-1:0]    coef_waddr_o,
  output logic [17:0]       coef_wdata_o
);

  localparam int CNT_W = WW + 17;

  logic [CNT_W-1:0] rcv_q, rcv_d, done_q, done_d, total, lag;
  logic [15:0]      orow_q, orow_d;
  logic [WW-1:0]    ocol_q, ocol_d;
  logic [LAW-1:0]   wp_q, wp_d;
  logic             take, frame_in, out_pend, pix_emit, drn_emit, emit, last;
  logic             is_coef, is_pix, is_drn;
  logic [31:0]      idx32;

  assign is_coef = (req_type_i == ic2d_pkg::REQ_COEF);
  assign is_pix  = (req_type_i == ic2d_pkg::REQ_PIXEL);
  assign is_drn  = (req_type_i == ic2d_pkg::REQ_DRAIN);

  assign total = CNT_W'(w_i) * CNT_W'(h_i);
  assign lag   = CNT_W'(kh_i >> 1) * CNT_W'(w_i) + CNT_W'(kw_i >> 1);

  assign frame_in = (rcv_q < total);
  assign out_pend = (done_q < total);
  assign pix_emit = frame_in && out_pend && ({1'b0, rcv_q} >= {1'b0, done_q} + {1'b0, lag});
  assign drn_emit = !frame_in && out_pend;
  assign last     = (done_q == total - CNT_W'(1));

  always_comb begin
    if (is_coef) begin
      in_ready_o = back_idle_i && q_empty_i;
    end else if (is_pix || is_drn) begin
      in_ready_o = !q_full_i;
    end else begin
      in_ready_o = 1'b1;
    end
  end

  assign take = in_valid_i && in_ready_o;
  assign emit = take && ((is_pix && pix_emit) || (is_drn && drn_emit));

  assign idx32        = 32'(coef_index_i);
  assign coef_we_o    = take && is_coef && (idx32 < 32'(CD));
  assign coef_waddr_o = CAW'(idx32);
  assign coef_wdata_o = coef_value_i;

  assign line_we_o    = take && is_pix && frame_in;
  assign line_waddr_o = wp_q;
  assign line_wdata_o = pixel_sample_i;

  assign q_push_o = emit;
  assign q_data_o = {orow_q, ocol_q,
                     LAW'(wp_q - LAW'(rcv_q) + LAW'(done_q) + LAW'(lag)), last};

  always_comb begin
    rcv_d  = rcv_q;
    done_d = done_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    wp_d   = wp_q;
    if (cfg_clear_i) begin
      rcv_d  = '0;
      done_d = '0;
      orow_d = '0;
      ocol_d = '0;
    end else begin
      if (line_we_o) begin
        wp_d  = wp_q + LAW'(1);
        rcv_d = rcv_q + CNT_W'(1);
      end
      if (emit) begin
        if (last) begin
          rcv_d  = '0;
          done_d = '0;
          orow_d = '0;
          ocol_d = '0;
        end else begin
          done_d = done_q + CNT_W'(1);
          if (ocol_q + WW'(1) >= w_i) begin
            ocol_d = '0;
            orow_d = orow_q + 16'd1;
          end else begin
            ocol_d = ocol_q + WW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q  <= '0;
      done_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      wp_q   <= '0;
    end else begin
      rcv_q  <= rcv_d;
      done_q <= done_d;
      orow_q <= orow_d;
      ocol_q <= ocol_d;
      wp_q   <= wp_d;
    end
  end

endmodule

FILE: sv/ic2d_back.sv
// ----------------------------------------------------------------------------
// ic2d_back
// Back end: walks the kernel taps of one job through a shared MAC, then
// rounds, clamps and holds the result word in the output register.
// ----------------------------------------------------------------------------
module ic2d_back #(
  parameter int MAX_WIDTH      = ic2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL     = ic2d_pkg::MAX_KERNEL_DEF,
  parameter int COEF_FRAC_BITS = ic2d_pkg::COEF_FRAC_BITS_DEF,
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int KW_W  = $clog2(MAX_KERNEL + 1),
  localparam int LAW   = ic2d_pkg::line_aw(MAX_WIDTH, MAX_KERNEL),
  localparam int CD    = MAX_KERNEL * MAX_KERNEL,
  localparam int CAW   = (CD > 1) ? $clog2(CD) : 1,
  localparam int QW    = 16 + WW + LAW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WW-1:0]      w_i,
  input  logic [15:0]        h_i,
  input  logic [KW_W-1:0]    kw_i,
  input  logic [KW_W-1:0]    kh_i,
  input  logic               q_empty_i,
  input  logic [QW-1:0]      q_data_i,
  output logic               q_pop_o,
  output logic               idle_o,
  output logic [LAW-1:0]     line_raddr_o,
  input  logic [15:0]        line_rdata_i,
  output logic [CAW-1:0]     coef_raddr_o,
  input  logic signed [17:0] coef_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        pixel_out_o,
  output logic               saturated_o,
  output logic               frame_end_o
);

  localparam int RW    = 18;
  localparam int CS    = WW + 2;
  localparam int PW    = 35;
  localparam int ACC_W = PW + $clog2(CD + 1) + 1;

  ic2d_pkg::back_state_e state_q, state_d;

  logic [15:0]            e_row;
  logic [WW-1:0]          e_col;
  logic [LAW-1:0]         e_base;
  logic                   e_last;
  logic                   pop, issue, finish, last_tap, inb;
  logic [KW_W-1:0]        m_q, n_q;
  logic signed [RW-1:0]   r_q;
  logic signed [CS-1:0]   c_q, c0_q;
  logic [LAW-1:0]         addr_q, rowaddr_q;
  logic [CAW-1:0]         cidx_q;
  logic                   last_q, flush_q, v1_q, v2_q, out_valid_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]       rnd, shifted;
  logic [15:0]            res_pix;
  logic                   res_sat;
  logic [15:0]            pix_q;
  logic                   sat_q, fend_q;

  assign {e_row, e_col, e_base, e_last} = q_data_i;

  assign last_tap = (n_q == kw_i - KW_W'(1)) && (m_q == kh_i - KW_W'(1));
  assign inb = !r_q[RW-1] && (r_q[RW-2:0] < (RW-1)'(h_i)) &&
               !c_q[CS-1] && (c_q[CS-2:0] < (CS-1)'(w_i));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ic2d_pkg::BK_IDLE:  if (!q_empty_i) state_d = ic2d_pkg::BK_RUN;
      ic2d_pkg::BK_RUN:   if (last_tap) state_d = ic2d_pkg::BK_FLUSH;
      ic2d_pkg::BK_FLUSH: if (flush_q) state_d = ic2d_pkg::BK_DONE;
      ic2d_pkg::BK_DONE:  if (!out_valid_q || out_ready_i) state_d = ic2d_pkg::BK_IDLE;
      default:            state_d = ic2d_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    case (state_q)
      ic2d_pkg::BK_IDLE: pop    = !q_empty_i;
      ic2d_pkg::BK_RUN:  issue  = 1'b1;
      ic2d_pkg::BK_DONE: finish = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign q_pop_o      = pop;
  assign idle_o       = (state_q == ic2d_pkg::BK_IDLE);
  assign line_raddr_o = addr_q;
  assign coef_raddr_o = cidx_q;

  // round half up, clamp
  assign rnd     = ACC_W'(acc_q) + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
  assign shifted = rnd >> COEF_FRAC_BITS;
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      res_pix = 16'd0;
      res_sat = 1'b0;
    end else if ((shifted >> 16) != '0) begin
      res_pix = 16'hFFFF;
      res_sat = 1'b1;
    end else begin
      res_pix = shifted[15:0];
      res_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ic2d_pkg::BK_IDLE;
      flush_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= (state_q == ic2d_pkg::BK_FLUSH) && !flush_q;
      v1_q    <= issue && inb;
      v2_q    <= v1_q;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(coef_rdata_i * $signed({1'b0, line_rdata_i}));
    if (pop) begin
      m_q       <= '0;
      n_q       <= '0;
      r_q       <= $signed(RW'(e_row) + RW'(kh_i >> 1));
      c_q       <= $signed(CS'(e_col) + CS'(kw_i >> 1));
      c0_q      <= $signed(CS'(e_col) + CS'(kw_i >> 1));
      addr_q    <= e_base;
      rowaddr_q <= e_base;
      cidx_q    <= '0;
      last_q    <= e_last;
      acc_q     <= '0;
    end else begin
      if (issue) begin
        cidx_q <= cidx_q + CAW'(1);
        if (n_q == kw_i - KW_W'(1)) begin
          m_q       <= m_q + KW_W'(1);
          n_q       <= '0;
          r_q       <= r_q - RW'(1);
          c_q       <= c0_q;
          rowaddr_q <= rowaddr_q - LAW'(w_i);
          addr_q    <= rowaddr_q - LAW'(w_i);
        end else begin
          n_q    <= n_q + KW_W'(1);
          c_q    <= c_q - CS'(1);
          addr_q <= addr_q - LAW'(1);
        end
      end
      if (v2_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (finish) begin
      pix_q  <= res_pix;
      sat_q  <= res_sat;
      fend_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign saturated_o = sat_q;
  assign frame_end_o = fend_q;

endmodule

FILE: sv/image_convolution_2d_core.sv
// ----------------------------------------------------------------------------
// image_convolution_2d_core
// Streaming 2D convolution of one image channel, zero padded borders.
// ----------------------------------------------------------------------------
// The front end accepts a coefficient, pixel or drain word whenever it is ready;
// a coefficient word waits until the MAC back end is idle and the job queue is
// empty, and a pixel or drain word waits while the queue is full. Each output
// pixel walks its kernel_width*kernel_height taps through the single shared
// multiply-accumulate, plus queue pop, read pipeline and result hand-off. A
// two-word job queue lets pixels keep arriving while an output is being computed.
module image_convolution_2d_core #(
  parameter int MAX_WIDTH      = ic2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL     = ic2d_pkg::MAX_KERNEL_DEF,
  parameter int COEF_FRAC_BITS = ic2d_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [17:0] coef_value_i,
  input  logic [15:0]        pixel_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        pixel_out_o,
  output logic               saturated_o,
  output logic               frame_end_o
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int KW_W = $clog2(MAX_KERNEL + 1);
  localparam int LAW  = ic2d_pkg::line_aw(MAX_WIDTH, MAX_KERNEL);
  localparam int CD   = MAX_KERNEL * MAX_KERNEL;
  localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int QW   = 16 + WW + LAW + 1;

  logic [11:0] img_w_q;
  logic [15:0] img_h_q;
  logic [2:0]  ker_w_q, ker_h_q;
  logic        cfg_take, cfg_clear;
  logic [31:0] w32, kw32, kh32;
  logic [WW-1:0]   w_eff;
  logic [15:0]     h_eff;
  logic [KW_W-1:0] kw_eff, kh_eff;

  logic            q_push, q_pop, q_full, q_empty, back_idle;
  logic [QW-1:0]   q_wdata, q_rdata;
  logic            line_we, coef_we;
  logic [LAW-1:0]  line_waddr, line_raddr;
  logic [15:0]     line_wdata, line_rdata;
  logic [CAW-1:0]  coef_waddr, coef_raddr;
  logic [17:0]     coef_wdata, coef_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_take && (cfg_index_i == ic2d_pkg::CFG_IMG_W ||
                                    cfg_index_i == ic2d_pkg::CFG_IMG_H ||
                                    cfg_index_i == ic2d_pkg::CFG_KER_W ||
                                    cfg_index_i == ic2d_pkg::CFG_KER_H);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 12'd640;
      img_h_q <= 16'd480;
      ker_w_q <= 3'd3;
      ker_h_q <= 3'd3;
    end else if (cfg_take) begin
      case (cfg_index_i)
        ic2d_pkg::CFG_IMG_W: img_w_q <= cfg_data_i[11:0];
        ic2d_pkg::CFG_IMG_H: img_h_q <= cfg_data_i;
        ic2d_pkg::CFG_KER_W: ker_w_q <= cfg_data_i[2:0];
        ic2d_pkg::CFG_KER_H: ker_h_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign w32  = 32'(img_w_q);
  assign kw32 = 32'(ker_w_q);
  assign kh32 = 32'(ker_h_q);
  assign w_eff  = (w32 == 0) ? WW'(1) : (w32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w32);
  assign h_eff  = (img_h_q == 16'd0) ? 16'd1 : img_h_q;
  assign kw_eff = (kw32 == 0) ? KW_W'(1) :
                  (kw32 > 32'(MAX_KERNEL)) ? KW_W'(MAX_KERNEL) : KW_W'(kw32);
  assign kh_eff = (kh32 == 0) ? KW_W'(1) :
                  (kh32 > 32'(MAX_KERNEL)) ? KW_W'(MAX_KERNEL) : KW_W'(kh32);

  ic2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_clear_i    (cfg_clear),
    .w_i            (w_eff),
    .h_i            (h_eff),
    .kw_i           (kw_eff),
    .kh_i           (kh_eff),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .pixel_sample_i (pixel_sample_i),
    .back_idle_i    (back_idle),
    .q_full_i       (q_full),
    .q_empty_i      (q_empty),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata),
    .line_we_o      (line_we),
    .line_waddr_o   (line_waddr),
    .line_wdata_o   (line_wdata),
    .coef_we_o      (coef_we),
    .coef_waddr_o   (coef_waddr),
    .coef_wdata_o   (coef_wdata)
  );

  ic2d_queue #(.DW(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ic2d_ram #(.W(16), .D(2 ** LAW)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  ic2d_ram #(.W(18), .D(CD)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  ic2d_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_KERNEL     (MAX_KERNEL),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .w_i          (w_eff),
    .h_i          (h_eff),
    .kw_i         (kw_eff),
    .kh_i         (kh_eff),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .idle_o       (back_idle),
    .line_raddr_o (line_raddr),
    .line_rdata_i (line_rdata),
    .coef_raddr_o (coef_raddr),
    .coef_rdata_i ($signed(coef_rdata)),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .saturated_o  (saturated_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

FILE: sv/ic2d_chk.sv
// ----------------------------------------------------------------------------
// ic2d_chk
// Port-level checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ic2d_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pixel_out_o,
  input logic        saturated_o,
  input logic        frame_end_o
);

  logic coef_take;

  assign coef_take = in_valid_i && in_ready_o && (req_type_i == ic2d_pkg::REQ_COEF);

  `IC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pixel_out_o) && $stable(frame_end_o))
  `IC_ASSERT_NOW(a_sat_max, out_valid_o && saturated_o, pixel_out_o == 16'hFFFF)
  `IC_ASSERT_NEXT(a_coef_quiet, coef_take, !$rose(out_valid_o))

endmodule

bind image_convolution_2d_core ic2d_chk u_ic2d_chk (.*);

FILE: sim/ic2d_checker.sv
// ----------------------------------------------------------------------------
// ic2d_checker
// Watches the config, input and output channels of the convolution core.
// Keeps its own line store, coefficients and counters, works out the expected
// output word when an accepted word completes one and compares each output word
// field by field. Reports the mismatch count and the number still expected.
// ----------------------------------------------------------------------------
module ic2d_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [17:0] coef_value_i,
  input  logic [15:0]        pixel_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        pixel_out_i,
  input  logic               saturated_i,
  input  logic               frame_end_i,
  output int                 pending_o,
  output int                 fails_o
);

  localparam int MaxW      = ic2d_pkg::MAX_WIDTH_DEF;
  localparam int MaxK      = ic2d_pkg::MAX_KERNEL_DEF;
  localparam int FracBits  = ic2d_pkg::COEF_FRAC_BITS_DEF;
  localparam int LineDepth = (MaxK - 1) * MaxW + MaxK;
  localparam int CoefDepth = MaxK * MaxK;

  typedef struct packed {
    logic [15:0] pixel;
    logic        sat;
    logic        last;
  } conv_out_t;

  logic [15:0]        line_mem [LineDepth];
  logic signed [17:0] coef_mem [CoefDepth];
  int unsigned        wr_ptr, in_col, in_row, out_col, out_row;
  logic [11:0]        img_w;
  logic [15:0]        img_h;
  logic [2:0]         ker_w, ker_h;
  conv_out_t          expected_q[$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic conv_out_t convolve(int unsigned w, int unsigned h, int unsigned rcvd);
    int unsigned kw, kh;
    longint      acc, r, c, q, d, res;
    int unsigned addr;
    conv_out_t   o;
    kw  = clamp_dim(ker_w, MaxK);
    kh  = clamp_dim(ker_h, MaxK);
    acc = 0;
    for (int m = 0; m < kh; m++) begin
      r = longint'(out_row) + kh / 2 - m;
      if (r < 0 || r >= h) continue;
      for (int n = 0; n < kw; n++) begin
        c = longint'(out_col) + kw / 2 - n;
        if (c < 0 || c >= w) continue;
        q = r * w + c;
        if (q >= rcvd) continue;
        d = longint'(rcvd) - q;
        if (d > LineDepth) continue;
        addr = (longint'(wr_ptr) + LineDepth - d) % LineDepth;
        acc += longint'(coef_mem[m * kw + n]) * longint'({1'b0, line_mem[addr]});
      end
    end
    o.sat = 1'b0;
    if (acc < 0) begin
      res = 0;
    end else begin
      res = (acc + (longint'(1) << (FracBits - 1))) >>> FracBits;
      if (res > 65535) begin
        res   = 65535;
        o.sat = 1'b1;
      end
    end
    o.pixel = res[15:0];
    o.last  = (out_row == h - 1) && (out_col == w - 1);
    if (o.last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return o;
  endfunction

  function automatic void predict_word(ic2d_pkg::req_e req, logic [5:0] idx,
                                       logic signed [17:0] cv, logic [15:0] pix);
    int unsigned w, h, kw, kh, rcvd;
    longint      lag, total, done;
    w     = clamp_dim(img_w, MaxW);
    h     = clamp_dim(img_h, 65535);
    kw    = clamp_dim(ker_w, MaxK);
    kh    = clamp_dim(ker_h, MaxK);
    lag   = longint'(kh / 2) * w + kw / 2;
    total = longint'(w) * h;
    done  = longint'(out_row) * w + out_col;
    case (req)
      ic2d_pkg::REQ_COEF: begin
        if (idx < CoefDepth) coef_mem[idx] = cv;
      end
      ic2d_pkg::REQ_PIXEL: begin
        if (in_row < h) begin
          line_mem[wr_ptr] = pix;
          wr_ptr = (wr_ptr + 1) % LineDepth;
          if (++in_col >= w) begin
            in_col = 0;
            in_row++;
          end
          rcvd = in_row * w + in_col;
          if (done < total && rcvd >= done + lag + 1)
            expected_q.push_back(convolve(w, h, rcvd));
        end
      end
      ic2d_pkg::REQ_DRAIN: begin
        if (in_row >= h && done < total)
          expected_q.push_back(convolve(w, h, total));
      end
      default: ;
    endcase
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    conv_out_t exp_o;
    if (!rst_ni) begin
      wr_ptr  <= 0;
      in_col  <= 0;
      in_row  <= 0;
      out_col <= 0;
      out_row <= 0;
      img_w   <= 12'd640;
      img_h   <= 16'd480;
      ker_w   <= 3'd3;
      ker_h   <= 3'd3;
      fails_o <= 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output word: pixel_out=%0d", pixel_out_i);
          fails_o <= fails_o + 1;
        end else begin
          exp_o = expected_q.pop_front();
          if (pixel_out_i !== exp_o.pixel || saturated_i !== exp_o.sat ||
              frame_end_i !== exp_o.last) begin
            if (pixel_out_i !== exp_o.pixel)
              $error("pixel_out: expected %0d, got %0d", exp_o.pixel, pixel_out_i);
            if (saturated_i !== exp_o.sat)
              $error("saturated: expected %0b, got %0b", exp_o.sat, saturated_i);
            if (frame_end_i !== exp_o.last)
              $error("frame_end: expected %0b, got %0b", exp_o.last, frame_end_i);
            fails_o <= fails_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ic2d_pkg::CFG_IMG_W: img_w = cfg_data_i[11:0];
          ic2d_pkg::CFG_IMG_H: img_h = cfg_data_i;
          ic2d_pkg::CFG_KER_W: ker_w = cfg_data_i[2:0];
          ic2d_pkg::CFG_KER_H: ker_h = cfg_data_i[2:0];
          default: ;
        endcase
        if (cfg_index_i <= ic2d_pkg::CFG_KER_H) begin
          in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
      end
      if (in_valid_i && in_ready_i)
        predict_word(ic2d_pkg::req_e'(req_type_i), coef_index_i, coef_value_i,
                     pixel_sample_i);
    end
  end

endmodule

FILE: sim/image_convolution_2d_core_tb.sv
// ----------------------------------------------------------------------------
// image_convolution_2d_core_tb
// Drives coefficient, pixel and drain words through frames of many sizes and
// kernel shapes, with random gaps on both sides, and takes the verdict from
// the checker that predicts and compares every output word.
// ----------------------------------------------------------------------------
module image_convolution_2d_core_tb;

  localparam int QuietCycles = 300;
  localparam int CycleLimit  = 4000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic [5:0]         coef_index_i;
  logic signed [17:0] coef_value_i;
  logic [15:0]        pixel_sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        pixel_out_o;
  logic               saturated_o;
  logic               frame_end_o;
  int                 pending, fails, cycles, words_sent;
  bit                 no_gaps;
  int unsigned        cur_w, cur_h, cur_kw, cur_kh;

  image_convolution_2d_core i_dut (.*);

  ic2d_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .coef_index_i,
    .coef_value_i, .pixel_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_out_i(pixel_out_o),
    .saturated_i(saturated_o), .frame_end_i(frame_end_o),
    .pending_o(pending), .fails_o(fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("image_convolution_2d_core_tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= 34);
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic send_word(ic2d_pkg::req_e req, logic [5:0] idx, logic signed [17:0] cv,
                           logic [15:0] pix);
    if (!no_gaps) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i     = 1'b1;
    req_type_i     = req;
    coef_index_i   = idx;
    coef_value_i   = cv;
    pixel_sample_i = pix;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    words_sent++;
  endtask

  task automatic wait_quiet();
    while (pending != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    if (!no_gaps) begin
      while ($urandom_range(99) < 34) @(negedge clk_i);
    end
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      ic2d_pkg::CFG_IMG_W: cur_w  = clamp_dim(data[11:0], ic2d_pkg::MAX_WIDTH_DEF);
      ic2d_pkg::CFG_IMG_H: cur_h  = clamp_dim(data, 65535);
      ic2d_pkg::CFG_KER_W: cur_kw = clamp_dim(data[2:0], ic2d_pkg::MAX_KERNEL_DEF);
      ic2d_pkg::CFG_KER_H: cur_kh = clamp_dim(data[2:0], ic2d_pkg::MAX_KERNEL_DEF);
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [15:0] w, logic [15:0] h, logic [15:0] kw, logic [15:0] kh);
    wait_quiet();
    write_reg(ic2d_pkg::CFG_IMG_W, w);
    write_reg(ic2d_pkg::CFG_IMG_H, h);
    write_reg(ic2d_pkg::CFG_KER_W, kw);
    write_reg(ic2d_pkg::CFG_KER_H, kh);
  endtask

  // 0: random over the full range, 1: all one value, 2: small weights from -200 to 1000
  task automatic load_coefs(int mode, logic signed [17:0] fixed_val);
    logic signed [17:0] v;
    for (int i = 0; i < ic2d_pkg::MAX_KERNEL_DEF * ic2d_pkg::MAX_KERNEL_DEF; i++) begin
      case (mode)
        0:       v = $urandom;
        1:       v = fixed_val;
        default: v = $urandom_range(1200) - 200;
      endcase
      send_word(ic2d_pkg::REQ_COEF, i, v, $urandom);
    end
  endtask

  // pixel mode 0: random, 1: all one value, 2: extremes and random mixed
  task automatic run_frame(int mode, logic [15:0] fixed_pix, bit noisy);
    int unsigned npix, lag;
    logic [15:0] p;
    npix = cur_w * cur_h;
    lag  = (cur_kh / 2) * cur_w + cur_kw / 2;
    for (int unsigned k = 0; k < npix; k++) begin
      if (noisy && $urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0: send_word(ic2d_pkg::REQ_DRAIN, $urandom, $urandom, $urandom);
          1: send_word(ic2d_pkg::REQ_NONE, $urandom, $urandom, $urandom);
          default: send_word(ic2d_pkg::REQ_COEF, $urandom, $urandom_range(1000), $urandom);
        endcase
      end
      case (mode)
        0: p = $urandom;
        1: p = fixed_pix;
        default: begin
          case ($urandom_range(3))
            0: p = 16'hffff;
            1: p = 16'h0000;
            default: p = $urandom;
          endcase
        end
      endcase
      send_word(ic2d_pkg::REQ_PIXEL, $urandom, $urandom, p);
    end
    for (int unsigned k = 0; k < lag + 2; k++) begin
      if (noisy && k < lag && $urandom_range(99) < 5)
        send_word(ic2d_pkg::REQ_PIXEL, $urandom, $urandom, $urandom);
      send_word(ic2d_pkg::REQ_DRAIN, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] w, h;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = ic2d_pkg::CFG_IMG_W;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    req_type_i     = ic2d_pkg::REQ_NONE;
    coef_index_i   = '0;
    coef_value_i   = '0;
    pixel_sample_i = '0;
    out_ready_i    = 1'b0;
    cycles         = 0;
    words_sent     = 0;
    no_gaps        = 1'b0;
    cur_w = 640; cur_h = 480; cur_kw = 3; cur_kh = 3;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: saturation, negative sums, ignored words, extreme registers
    set_shape(4, 3, 3, 3);
    load_coefs(1, 18'sh1ffff);
    send_word(ic2d_pkg::REQ_COEF, 6'd63, 18'sh20000, 16'hffff);
    send_word(ic2d_pkg::REQ_COEF, 6'd49, 18'sh20000, 16'h0000);
    send_word(ic2d_pkg::REQ_NONE, 6'h3f, 18'sh1ffff, 16'hffff);
    send_word(ic2d_pkg::REQ_DRAIN, '0, '0, '0);
    run_frame(1, 16'hffff, 1'b0);
    load_coefs(1, 18'sh20000);
    run_frame(2, 16'h0, 1'b0);
    set_shape(16'hffff, 16'hffff, 0, 0);
    load_coefs(2, 0);
    for (int k = 0; k < 6; k++) send_word(ic2d_pkg::REQ_PIXEL, '0, '0, $urandom);
    set_shape(1, 0, 7, 7);
    run_frame(0, 0, 1'b0);
    no_gaps = 1'b1;
    set_shape(160, 2, 7, 1);
    run_frame(0, 0, 1'b0);
    no_gaps = 1'b0;

    // random frames
    while (words_sent < 900) begin
      no_gaps = ($urandom_range(9) == 0);
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(200, 64);
        h = $urandom_range(1);
      end else begin
        w = $urandom_range(12);
        h = $urandom_range(8);
      end
      set_shape(w, h, $urandom_range(7), $urandom_range(7));
      if ($urandom_range(3) == 0) load_coefs($urandom_range(2) == 0 ? 0 : 2, 0);
      run_frame($urandom_range(2), $urandom, $urandom_range(1));
    end
    no_gaps = 1'b0;

    wait_quiet();
    if (fails == 0) begin
      $display("image_convolution_2d_core_tb passed");
    end else begin
      $display("image_convolution_2d_core_tb failed");
    end
    $finish;
  end

endmodule
